>>> src/ucit_pkg.sv
// ----------------------------------------------------------------------------
// Unknown CAN identifier tracker package
// Shared sizes, status codes and the request record passed front to back.
// ----------------------------------------------------------------------------
package ucit_pkg;

  localparam int unsigned Entries    = 32;
  localparam int unsigned SlotW      = $clog2(Entries);
  localparam int unsigned CountW     = $clog2(Entries + 1);
  localparam int unsigned MaxBytes   = 8;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    StUpdated = 3'd0,
    StNew     = 3'd1,
    StFull    = 3'd2,
    StReadOk  = 3'd3,
    StReadBad = 3'd4
  } status_e;

  typedef enum logic {
    ReqNote = 1'b0,
    ReqRead = 1'b1
  } req_e;

  // One classified request: the lookup is already done by the front part.
  typedef struct packed {
    status_e          status;
    logic             found;
    logic [SlotW-1:0] slot;
    logic [3:0]       len;
    logic [63:0]      data;
    logic [62:0]      stamp;
    logic [31:0]      frame_id;
  } job_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < MaxBytes; b++) begin
      if (4'(b) < len) m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

>>> src/ucit_front.sv
// ----------------------------------------------------------------------------
// Tracker front
// Accepts requests, matches the identifier against all occupied entries in
// parallel, appends new identifiers and keeps the occupancy and drop counts.
// ----------------------------------------------------------------------------
module ucit_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic                    req_type_i,
  input  logic [31:0]             frame_id_i,
  input  logic [63:0]             payload_i,
  input  logic [3:0]              payload_length_i,
  input  logic [62:0]             time_us_i,
  input  logic [4:0]              read_index_i,
  output logic                    job_valid_o,
  input  logic                    job_ready_i,
  output ucit_pkg::job_t          job_o,
  output logic [ucit_pkg::CountW-1:0] used_o,
  output logic [31:0]             dropped_o
);
  import ucit_pkg::*;

  logic [31:0]       ids_q [Entries];
  logic [CountW-1:0] used_q, used_d;
  logic [31:0]       dropped_q, dropped_d;
  logic              fire, hit;
  logic [SlotW-1:0]  hit_slot;
  logic [3:0]        len_sat;
  job_t              job;

  assign ready_o     = job_ready_i;
  assign job_valid_o = valid_i;
  assign fire        = valid_i && job_ready_i;
  assign len_sat     = (payload_length_i > 4'(MaxBytes)) ? 4'(MaxBytes) : payload_length_i;

  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (CountW'(i) < used_q && ids_q[i] == frame_id_i) begin
        hit      = 1'b1;
        hit_slot = SlotW'(i);
      end
    end
  end

  always_comb begin
    used_d        = used_q;
    dropped_d     = dropped_q;
    job.found     = hit;
    job.len       = len_sat;
    job.data      = payload_i & byte_mask(len_sat);
    job.stamp     = time_us_i;
    job.frame_id  = frame_id_i;
    job.slot      = hit_slot;
    job.status    = StUpdated;
    if (req_type_i == ReqRead) begin
      job.slot   = SlotW'(read_index_i);
      job.status = ({1'b0, read_index_i} < 6'(used_q)) ? StReadOk : StReadBad;
    end else if (!hit) begin
      if (used_q >= CountW'(Entries)) begin
        job.status = StFull;
        dropped_d  = dropped_q + 32'd1;
      end else begin
        job.status = StNew;
        job.slot   = used_q[SlotW-1:0];
        used_d     = used_q + CountW'(1);
      end
    end
  end

  assign job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      dropped_q <= '0;
    end else if (fire) begin
      used_q    <= used_d;
      dropped_q <= dropped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && job.status == StNew) ids_q[job.slot] <= frame_id_i;
  end

  assign used_o    = used_d;
  assign dropped_o = dropped_d;

endmodule

>>> src/ucit_queue.sv
// ----------------------------------------------------------------------------
// Tracker job queue
// Short FIFO between front and back, carrying the job and counter snapshot.
// ----------------------------------------------------------------------------
module ucit_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  ucit_pkg::job_t          in_job_i,
  input  logic [ucit_pkg::CountW-1:0] in_used_i,
  input  logic [31:0]             in_dropped_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output ucit_pkg::job_t          out_job_o,
  output logic [ucit_pkg::CountW-1:0] out_used_o,
  output logic [31:0]             out_dropped_o
);
  import ucit_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t              job_q  [QueueDepth];
  logic [CountW-1:0] used_q [QueueDepth];
  logic [31:0]       drop_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;
  logic              push, pop;

  assign in_ready_o  = (cnt_q != (PtrW+1)'(QueueDepth));
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + PtrW'(1);
      if (pop)  rd_q <= rd_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      job_q[wr_q]  <= in_job_i;
      used_q[wr_q] <= in_used_i;
      drop_q[wr_q] <= in_dropped_i;
    end
  end

  assign out_job_o     = job_q[rd_q];
  assign out_used_o    = used_q[rd_q];
  assign out_dropped_o = drop_q[rd_q];

endmodule

>>> src/ucit_back.sv
// ----------------------------------------------------------------------------
// Tracker back
// Reads the entry record, applies the update, writes it back and presents
// the result in an output register.
// ----------------------------------------------------------------------------
module ucit_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    job_valid_i,
  output logic                    job_ready_o,
  input  ucit_pkg::job_t          job_i,
  input  logic [ucit_pkg::CountW-1:0] used_i,
  input  logic [31:0]             dropped_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [2:0]              status_o,
  output logic                    changed_o,
  output logic [4:0]              slot_o,
  output logic [31:0]             entry_id_o,
  output logic [3:0]              entry_length_o,
  output logic [63:0]             entry_data_o,
  output logic [31:0]             frame_count_o,
  output logic [31:0]             change_count_o,
  output logic [62:0]             last_time_us_o,
  output logic [5:0]              entries_used_o,
  output logic [31:0]             dropped_count_o
);
  import ucit_pkg::*;

  typedef enum logic [1:0] {
    SIdle,
    SRead,
    SOut
  } state_e;

  typedef struct packed {
    logic [31:0] id;
    logic [3:0]  len;
    logic [63:0] data;
    logic [31:0] frames;
    logic [31:0] changes;
    logic [62:0] stamp;
  } rec_t;

  rec_t        mem_q [Entries];
  rec_t        rd_q, wr_rec;
  state_e      state_q;
  job_t        job_q;
  logic [CountW-1:0] used_q;
  logic [31:0] drop_q;
  logic        diff, do_write;
  rec_t        res_rec;
  logic        res_chg;

  assign job_ready_o = (state_q == SIdle);
  assign valid_o     = (state_q == SOut);

  always_comb begin
    diff = (job_q.status == StNew) || rd_q.len != job_q.len || rd_q.data != job_q.data;
    wr_rec.id      = job_q.frame_id;
    wr_rec.len     = job_q.len;
    wr_rec.data    = job_q.data;
    wr_rec.stamp   = job_q.stamp;
    wr_rec.frames  = (job_q.status == StNew) ? 32'd1 : rd_q.frames + 32'd1;
    wr_rec.changes = (job_q.status == StNew) ? 32'd1 : rd_q.changes + 32'(diff);
    do_write = (job_q.status == StNew) || (job_q.status == StUpdated);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      unique case (state_q)
        SIdle: if (job_valid_i) state_q <= SRead;
        SRead: state_q <= SOut;
        SOut:  if (ready_i) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && job_valid_i) begin
      job_q  <= job_i;
      used_q <= used_i;
      drop_q <= dropped_i;
      rd_q   <= mem_q[job_i.slot];
    end
    if (state_q == SRead) begin
      if (do_write) mem_q[job_q.slot] <= wr_rec;
      res_chg <= do_write && diff;
      if (do_write) res_rec <= wr_rec;
      else if (job_q.status == StReadOk) res_rec <= rd_q;
      else res_rec <= '0;
    end
  end

  assign status_o        = job_q.status;
  assign changed_o       = res_chg;
  assign slot_o          = (job_q.status == StFull || job_q.status == StReadBad)
                           ? 5'd0 : 5'(job_q.slot);
  assign entry_id_o      = res_rec.id;
  assign entry_length_o  = res_rec.len;
  assign entry_data_o    = res_rec.data;
  assign frame_count_o   = res_rec.frames;
  assign change_count_o  = res_rec.changes;
  assign last_time_us_o  = res_rec.stamp;
  assign entries_used_o  = 6'(used_q);
  assign dropped_count_o = drop_q;

endmodule

>>> src/unknown_can_id_tracker_core.sv
// ----------------------------------------------------------------------------
// Unknown CAN identifier tracker
// Each item is queued, then the back part reads its entry, writes it back and
// holds the result in its output state until taken; only then is a new item taken.
// The front accepts while the two-deep queue has room.
// Reset clears occupancy, drop count, queue and state; entries are undefined.
// ----------------------------------------------------------------------------
module unknown_can_id_tracker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic        req_type_i,
  input  logic [31:0] frame_id_i,
  input  logic [63:0] payload_i,
  input  logic [3:0]  payload_length_i,
  input  logic [62:0] time_us_i,
  input  logic [4:0]  read_index_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [2:0]  status_o,
  output logic        changed_o,
  output logic [4:0]  slot_o,
  output logic [31:0] entry_id_o,
  output logic [3:0]  entry_length_o,
  output logic [63:0] entry_data_o,
  output logic [31:0] frame_count_o,
  output logic [31:0] change_count_o,
  output logic [62:0] last_time_us_o,
  output logic [5:0]  entries_used_o,
  output logic [31:0] dropped_count_o
);
  import ucit_pkg::*;

  logic              f_valid, f_ready, b_valid, b_ready;
  job_t              f_job, b_job;
  logic [CountW-1:0] f_used, b_used;
  logic [31:0]       f_drop, b_drop;

  ucit_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .req_type_i, .frame_id_i, .payload_i,
    .payload_length_i, .time_us_i, .read_index_i,
    .job_valid_o(f_valid), .job_ready_i(f_ready), .job_o(f_job),
    .used_o(f_used), .dropped_o(f_drop)
  );

  ucit_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_job_i(f_job),
    .in_used_i(f_used), .in_dropped_i(f_drop),
    .out_valid_o(b_valid), .out_ready_i(b_ready), .out_job_o(b_job),
    .out_used_o(b_used), .out_dropped_o(b_drop)
  );

  ucit_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(b_valid), .job_ready_o(b_ready), .job_i(b_job),
    .used_i(b_used), .dropped_i(b_drop),
    .valid_o, .ready_i, .status_o, .changed_o, .slot_o, .entry_id_o,
    .entry_length_o, .entry_data_o, .frame_count_o, .change_count_o,
    .last_time_us_o, .entries_used_o, .dropped_count_o
  );

  a_used_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_used <= CountW'(Entries)) else $error("occupancy beyond table size");

  a_new_changed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == StNew |-> changed_o && frame_count_o == 32'd1)
    else $error("new entry not flagged as changed");

  a_drop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == StFull |-> !changed_o && slot_o == 5'd0)
    else $error("dropped frame reports an entry");

endmodule
